// ===== hw/rtl/ritp_pkg.sv =====
// ----------------------------------------------------------------------------
// ritp_pkg: shared types and constants of the radix integer text parser
// Field widths, character classes, parse phases and the queue entry.
// ----------------------------------------------------------------------------
package ritp_pkg;

    localparam int VALUE_WIDTH     = 64;
    localparam int COUNT_WIDTH     = 16;
    localparam int CH_WIDTH        = 8;
    localparam int RADIX_WIDTH     = 6;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

    localparam int MAX_RADIX = 36;
    localparam int HEX_RADIX = 16;
    localparam int OCT_RADIX = 8;
    localparam int DEC_RADIX = 10;

    // digit code for a byte that is no digit or letter: never below a base
    localparam logic [RADIX_WIDTH-1:0] DIGIT_NONE = '1;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIX       = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIGNED_MODE = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_PREFIX,
        PH_ZERO,
        PH_HEXX,
        PH_DIGITS
    } t_phase;

    // one classified character, with the configuration it was taken under
    typedef struct packed {
        logic                   first;
        logic [RADIX_WIDTH-1:0] digit;
        logic                   is_ws;
        logic                   is_plus;
        logic                   is_minus;
        logic                   is_zero;
        logic                   is_x;
        logic [RADIX_WIDTH-1:0] radix;
        logic                   signed_mode;
    } t_item;

endpackage

// ===== hw/rtl/ritp_front.sv =====
// ----------------------------------------------------------------------------
// ritp_front: request intake and character classification
// Holds the configuration registers, classifies each character and pushes it
// into the queue together with the current configuration.
// ----------------------------------------------------------------------------
module ritp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ritp_pkg::CH_WIDTH-1:0]       i_ch,
    input  logic                                i_first,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ritp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [ritp_pkg::RADIX_WIDTH-1:0]    i_cfg_data,
    input  logic                                i_full,
    output logic                                o_push,
    output ritp_pkg::t_item                     o_item
);

    logic [ritp_pkg::RADIX_WIDTH-1:0] r_radix;
    logic                             r_signed_mode;
    logic [ritp_pkg::CH_WIDTH-1:0]    w_off;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_full;
    assign o_push      = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= ritp_pkg::RADIX_WIDTH'(ritp_pkg::DEC_RADIX);
            r_signed_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ritp_pkg::REG_RADIX:       r_radix       <= i_cfg_data;
                ritp_pkg::REG_SIGNED_MODE: r_signed_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // offset from the character to its digit value
    always_comb begin
        w_off = i_ch;
        if (i_ch inside {["0":"9"]}) begin
            w_off = i_ch - 8'd48;
        end else if (i_ch inside {["A":"Z"]}) begin
            w_off = i_ch - 8'd55;
        end else if (i_ch inside {["a":"z"]}) begin
            w_off = i_ch - 8'd87;
        end
    end

    always_comb begin
        o_item.first       = i_first;
        o_item.is_ws       = (i_ch == 8'd32) || (i_ch inside {[8'd9:8'd13]});
        o_item.is_plus     = (i_ch == "+");
        o_item.is_minus    = (i_ch == "-");
        o_item.is_zero     = (i_ch == "0");
        o_item.is_x        = (i_ch == "x") || (i_ch == "X");
        o_item.radix       = r_radix;
        o_item.signed_mode = r_signed_mode;
        if (i_ch inside {["0":"9"], ["A":"Z"], ["a":"z"]}) begin
            o_item.digit = w_off[ritp_pkg::RADIX_WIDTH-1:0];
        end else begin
            o_item.digit = ritp_pkg::DIGIT_NONE;
        end
    end

endmodule

// ===== hw/rtl/ritp_queue.sv =====
// ----------------------------------------------------------------------------
// ritp_queue: short queue between front and back
// Two entries of classified characters; either side may stall on its own.
// ----------------------------------------------------------------------------
module ritp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ritp_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ritp_pkg::t_item o_item
);

    localparam int PW = ritp_pkg::QUEUE_PTR_WIDTH;

    ritp_pkg::t_item   r_mem [ritp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW:0]       r_fill;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_fill == (PW+1)'(ritp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

endmodule

// ===== hw/rtl/ritp_back.sv =====
// ----------------------------------------------------------------------------
// ritp_back: parse sequencer and accumulator
// Steps the parse phases one character a cycle, unless a result waits to be taken
// when the string ends, runs the multiply-add and holds the result in an output
// register until it is taken.
module ritp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  ritp_pkg::t_item                     i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ritp_pkg::VALUE_WIDTH-1:0]    o_value,
    output logic [ritp_pkg::COUNT_WIDTH-1:0]    o_consumed
);

    localparam int VW = ritp_pkg::VALUE_WIDTH;
    localparam int CW = ritp_pkg::COUNT_WIDTH;
    localparam int RW = ritp_pkg::RADIX_WIDTH;

    ritp_pkg::t_phase r_phase, n_phase;
    logic [VW-1:0]    r_acc, n_acc;
    logic             r_neg, n_neg;
    logic [RW-1:0]    r_base, n_base;
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid;
    logic [VW-1:0]    r_out_value;
    logic [CW-1:0]    r_out_count;

    logic             w_clear;
    logic             w_bump;
    logic             w_mac;
    logic             w_emit;
    logic             w_stop;
    logic [CW-1:0]    w_count;
    logic [VW-1:0]    w_acc_src;
    logic [VW+RW-1:0] w_prod;
    logic             w_out_free;
    logic             w_fire;

    // next state: walk the phases for one character
    always_comb begin
        n_phase = r_phase;
        n_base  = r_base;
        n_neg   = r_neg;
        w_count = r_count;
        w_clear = 1'b0;
        w_bump  = 1'b0;
        w_mac   = 1'b0;
        w_emit  = 1'b0;
        w_stop  = 1'b0;
        if (i_item.first) begin
            n_neg   = 1'b0;
            w_count = '0;
            w_clear = 1'b1;
            n_base  = i_item.radix;
            if (i_item.radix == RW'(1) || i_item.radix > RW'(ritp_pkg::MAX_RADIX)) begin
                n_phase = ritp_pkg::PH_IDLE;
                w_emit  = 1'b1;
                w_stop  = 1'b1;
            end else begin
                n_phase = ritp_pkg::PH_SPACE;
            end
        end
        if (!w_stop && n_phase == ritp_pkg::PH_IDLE) begin
            w_stop = 1'b1;
        end
        if (!w_stop && n_phase == ritp_pkg::PH_SPACE) begin
            if (i_item.is_ws) begin
                w_bump = 1'b1;
                w_stop = 1'b1;
            end else begin
                n_phase = ritp_pkg::PH_PREFIX;
                if (i_item.signed_mode && (i_item.is_plus || i_item.is_minus)) begin
                    n_neg  = i_item.is_minus;
                    w_bump = 1'b1;
                    w_stop = 1'b1;
                end
            end
        end
        if (!w_stop && n_phase == ritp_pkg::PH_PREFIX) begin
            if (n_base == '0) begin
                if (i_item.is_zero) begin
                    n_phase = ritp_pkg::PH_ZERO;
                    w_bump  = 1'b1;
                    w_stop  = 1'b1;
                end else begin
                    n_base  = RW'(ritp_pkg::DEC_RADIX);
                    n_phase = ritp_pkg::PH_DIGITS;
                end
            end else if (n_base == RW'(ritp_pkg::HEX_RADIX)) begin
                n_phase = ritp_pkg::PH_HEXX;
                if (i_item.is_zero) begin
                    w_bump = 1'b1;
                    w_stop = 1'b1;
                end
            end else begin
                n_phase = ritp_pkg::PH_DIGITS;
            end
        end
        if (!w_stop && n_phase == ritp_pkg::PH_ZERO) begin
            n_phase = ritp_pkg::PH_DIGITS;
            if (i_item.is_x) begin
                n_base = RW'(ritp_pkg::HEX_RADIX);
                w_bump = 1'b1;
                w_stop = 1'b1;
            end else begin
                n_base = RW'(ritp_pkg::OCT_RADIX);
            end
        end
        if (!w_stop && n_phase == ritp_pkg::PH_HEXX) begin
            n_phase = ritp_pkg::PH_DIGITS;
            if (i_item.is_x) begin
                w_bump = 1'b1;
                w_stop = 1'b1;
            end
        end
        if (!w_stop) begin
            if (i_item.digit < n_base) begin
                w_mac  = 1'b1;
                w_bump = 1'b1;
            end else begin
                w_emit  = 1'b1;
                n_phase = ritp_pkg::PH_IDLE;
            end
        end
    end

    // outputs: datapath values and handshake
    always_comb begin
        w_acc_src  = w_clear ? '0 : r_acc;
        w_prod     = w_acc_src * n_base;
        n_acc      = w_mac ? (w_prod[VW-1:0] + VW'(i_item.digit)) : w_acc_src;
        n_count    = (w_bump && w_count != '1) ? w_count + 1'b1 : w_count;
        w_out_free = !r_out_valid || i_ready;
        w_fire     = i_q_valid && (!w_emit || w_out_free);
        o_pop      = w_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ritp_pkg::PH_IDLE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_base  <= '0;
            r_count <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // capture the result; negate when a minus sign was taken
    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_value <= n_neg ? (VW'(0) - w_acc_src) : w_acc_src;
            r_out_count <= w_count;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_value    = r_out_value;
    assign o_consumed = r_out_count;

endmodule

// ===== hw/rtl/radix_integer_text_parser_core.sv =====
// ----------------------------------------------------------------------------
// radix_integer_text_parser_core: streaming strtol-style integer parser
// Front classifies characters, a two-entry queue decouples it from the back,
// which runs the parse phases and the multiply-add.
// ----------------------------------------------------------------------------
// Send one character per request, with first set on the first character of
// each string. The block takes one character every clock cycle, except that
// a terminating one waits until the last result is taken; that figure is set
// by the back stage, which does the whole phase step and one 64-by-6-bit
// multiply-add into the accumulator per cycle. A result (value and consumed
// count) is registered as the back stage takes the terminating character,
// held until taken; intake goes on until the queue fills. The radix and
// signed_mode registers may be written at any time the parser has nothing
// in flight; they take effect for characters requested after the write.
module radix_integer_text_parser_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [ritp_pkg::CH_WIDTH-1:0]        i_ch,
    input  logic                                 i_first,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [ritp_pkg::VALUE_WIDTH-1:0]     o_value,
    output logic [ritp_pkg::COUNT_WIDTH-1:0]     o_consumed,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ritp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [ritp_pkg::RADIX_WIDTH-1:0]     i_cfg_data
);

    ritp_pkg::t_item w_push_item;
    ritp_pkg::t_item w_head_item;
    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_q_valid;

    ritp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_ch        (i_ch),
        .i_first     (i_first),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    ritp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_head_item)
    );

    ritp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_item     (w_head_item),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_value    (o_value),
        .o_consumed (o_consumed)
    );

endmodule
